/* rtl/core/cpt_pkg.sv */
// Shared types and constants for the circular prime test core.
`default_nettype none

package cpt_pkg;

  // Default maximum number of decimal digits counted in a value.
  localparam int unsigned MAX_DIGITS_DEF = 10;

  // Width of the input value and the reported rotation.
  localparam int unsigned VALUE_W = 32;

  // Width of a rotation before it is cut to 32 bits (10^10 needs 34 bits).
  localparam int unsigned WIDE_W = 34;

  // Trial divisors run up to 65537, which needs 17 bits.
  localparam int unsigned DIVISOR_W = 17;

  // Reciprocal of ten scaled by 2^37; exact for every dividend below 2^34.
  localparam logic [WIDE_W-1:0] RECIP10    = 34'd13743895348;
  localparam int unsigned       RECIP10_SH = 37;

  // Operand selection for the shared divider.
  typedef enum logic [1:0] {
    DIV_MODV  = 2'd0,  // value mod 10^n
    DIV_TRIAL = 2'd1   // candidate mod trial divisor
  } div_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load_in;
    logic     cnt_step;
    logic     div_start;
    div_sel_e div_sel;
    logic     load_r_mod;
    logic     prime_init;
    logic     trial_next;
    logic     rot_mul_lo;
    logic     rot_mul_hi;
    logic     rot_update;
    logic     res_load;
    logic     res_pass;
  } cpt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_more;
    logic div_done;
    logic rem_zero;
    logic c_small;
    logic sq_over;
    logic rot_last;
    logic out_free;
  } cpt_sts_t;

endpackage

`default_nettype wire

/* rtl/core/circular_prime_test_core.sv */
// Top level of the decimal circular prime test core.
//
//   Channel | Direction | Handshake              | Payload
//   --------+-----------+------------------------+----------------------------------
//   input   | in        | in_valid_i/in_ready_o   | value_i[31:0]
//   output  | out       | out_valid_o/out_ready_i | is_circular_o, failed_rotation_o
//
// An item counts its digits, runs one divider pass and then tests each rotation in turn.
// A rotation is tested with trial divisors: 2, then odd divisors up to the square root,
// at most about 32768 per rotation; a rotation that fails on a divisor ends the item.
// Each trial divisor costs a check state and a pass of the shared radix-4 divider.
// Moving to the next rotation is a split by ten through the ST_ROT_HI and ST_ROT_UPD states.
// Reset clears the controller and the output valid flag; no clearing pass is needed.
// A new item is taken as soon as the controller is idle, even while the last
// result still waits in the output register; a finished item stalls until it is free.
`default_nettype none

module circular_prime_test_core #(
  parameter int unsigned MAX_DIGITS = cpt_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [cpt_pkg::VALUE_W-1:0]  value_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              is_circular_o,
  output logic [cpt_pkg::VALUE_W-1:0]       failed_rotation_o
);
  import cpt_pkg::*;

  cpt_cmd_t cmd;
  cpt_sts_t sts;

  // Sequencer.
  cpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Arithmetic and result register.
  cpt_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .value_i           (value_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .is_circular_o     (is_circular_o),
    .failed_rotation_o (failed_rotation_o)
  );

endmodule

`default_nettype wire

/* rtl/core/cpt_div.sv */
// Iterative restoring divider, two quotient bits per cycle.
`default_nettype none

module cpt_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [cpt_pkg::WIDE_W-1:0]  dividend_i,
  input  wire logic [cpt_pkg::WIDE_W-1:0]  divisor_i,
  output logic                             done_o,
  output logic [cpt_pkg::WIDE_W-1:0]       quo_o,
  output logic [cpt_pkg::WIDE_W-1:0]       rem_o
);
  import cpt_pkg::*;

  localparam int unsigned ITER  = WIDE_W / 2;
  localparam int unsigned CNT_W = $clog2(ITER);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [WIDE_W-1:0] quo_q, rem_q, dvs_q;

  logic [WIDE_W:0]   t1, t2;
  logic              ge1, ge2;
  logic [WIDE_W-1:0] r1, r2, q1, q2;

  // Two dependent shift and subtract steps.
  always_comb begin
    t1  = {rem_q, quo_q[WIDE_W-1]};
    ge1 = (t1 >= {1'b0, dvs_q});
    r1  = ge1 ? WIDE_W'(t1 - {1'b0, dvs_q}) : WIDE_W'(t1);
    q1  = {quo_q[WIDE_W-2:0], ge1};
    t2  = {r1, q1[WIDE_W-1]};
    ge2 = (t2 >= {1'b0, dvs_q});
    r2  = ge2 ? WIDE_W'(t2 - {1'b0, dvs_q}) : WIDE_W'(t2);
    q2  = {q1[WIDE_W-2:0], ge2};
  end

  // Control: busy flag, iteration count and done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CNT_W'(ITER - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  // Operands and partial results.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= q2;
      rem_q <= r2;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

/* rtl/core/cpt_dp.sv */
// Datapath: digit count, rotations, trial division and result register.
`default_nettype none

module cpt_dp #(
  parameter int unsigned MAX_DIGITS = cpt_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire cpt_pkg::cpt_cmd_t            cmd_i,
  output cpt_pkg::cpt_sts_t                 sts_o,
  input  wire logic [cpt_pkg::VALUE_W-1:0]  value_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              is_circular_o,
  output logic [cpt_pkg::VALUE_W-1:0]       failed_rotation_o
);
  import cpt_pkg::*;

  localparam int unsigned NW     = $clog2(MAX_DIGITS + 1);
  localparam int unsigned HALF_W = WIDE_W / 2;
  localparam int unsigned PROD_W = HALF_W + WIDE_W;
  localparam int unsigned ACC_W  = 2 * WIDE_W;

  logic [VALUE_W-1:0]   v_q, c_q, fail_val_q;
  logic [WIDE_W-1:0]    pow_hi_q, pow10_q, r_q, sq_q;
  logic [NW-1:0]        n_q, rot_q;
  logic [DIVISOR_W-1:0] d_q;
  logic                 out_valid_q, circ_q;
  logic [PROD_W-1:0]    prod_lo_q;
  logic [WIDE_W-1:0]    quo10_q;

  logic [WIDE_W-1:0]    div_a, div_b, div_quo, div_rem;
  logic                 div_done;
  logic [WIDE_W-1:0]    pow10_x10, rot_next, sq_next;
  logic [PROD_W-1:0]    prod_lo, prod_hi;
  logic [ACC_W-1:0]     acc;
  logic [3:0]           rot_digit;

  // Divider operand selection.
  always_comb begin
    unique case (cmd_i.div_sel)
      DIV_MODV: begin
        div_a = WIDE_W'(v_q);
        div_b = pow10_q;
      end
      DIV_TRIAL: begin
        div_a = WIDE_W'(c_q);
        div_b = WIDE_W'(d_q);
      end
      default: begin
        div_a = WIDE_W'(v_q);
        div_b = pow10_q;
      end
    endcase
  end

  cpt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // Rotation split by ten: multiply by the scaled reciprocal one half at a time.
  assign prod_lo = PROD_W'(r_q[HALF_W-1:0]) * PROD_W'(RECIP10);
  assign prod_hi = PROD_W'(r_q[WIDE_W-1:HALF_W]) * PROD_W'(RECIP10);
  assign acc     = ACC_W'(prod_lo_q) + {prod_hi, {HALF_W{1'b0}}};

  // The last digit only needs the low four bits of r - 10 * q.
  assign rot_digit = r_q[3:0] - ({quo10_q[0], 3'b000} + {quo10_q[2:0], 1'b0});

  // Next power of ten, next rotation and next divisor square.
  assign pow10_x10 = WIDE_W'({pow10_q, 3'b000}) + WIDE_W'({pow10_q, 1'b0});
  assign rot_next  = quo10_q + WIDE_W'(pow_hi_q * WIDE_W'(rot_digit));
  assign sq_next   = sq_q + WIDE_W'({d_q, 2'b00}) + WIDE_W'(4);

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      v_q      <= value_i;
      pow_hi_q <= WIDE_W'(1);
      pow10_q  <= WIDE_W'(10);
      n_q      <= NW'(1);
      rot_q    <= '0;
    end
    if (cmd_i.cnt_step) begin
      pow_hi_q <= pow10_q;
      pow10_q  <= pow10_x10;
      n_q      <= n_q + NW'(1);
    end
    if (cmd_i.load_r_mod) begin
      r_q <= div_rem;
    end
    if (cmd_i.rot_mul_lo) begin
      prod_lo_q <= prod_lo;
    end
    if (cmd_i.rot_mul_hi) begin
      quo10_q <= WIDE_W'(acc[ACC_W-1:RECIP10_SH]);
    end
    if (cmd_i.rot_update) begin
      r_q   <= rot_next;
      rot_q <= rot_q + NW'(1);
    end
    if (cmd_i.prime_init) begin
      c_q  <= r_q[VALUE_W-1:0];
      d_q  <= DIVISOR_W'(2);
      sq_q <= WIDE_W'(4);
    end
    if (cmd_i.trial_next) begin
      if (d_q == DIVISOR_W'(2)) begin
        d_q  <= DIVISOR_W'(3);
        sq_q <= WIDE_W'(9);
      end else begin
        d_q  <= d_q + DIVISOR_W'(2);
        sq_q <= sq_next;
      end
    end
  end

  // Result register; a finished result waits here for its transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      circ_q     <= cmd_i.res_pass;
      fail_val_q <= cmd_i.res_pass ? '0 : c_q;
    end
  end

  // Status toward the controller.
  always_comb begin
    sts_o.cnt_more = (WIDE_W'(v_q) >= pow10_q) && (n_q < NW'(MAX_DIGITS));
    sts_o.div_done = div_done;
    sts_o.rem_zero = (div_rem == '0);
    sts_o.c_small  = (c_q < VALUE_W'(2));
    sts_o.sq_over  = (sq_q > WIDE_W'(c_q));
    sts_o.rot_last = ((rot_q + NW'(1)) == n_q);
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o       = out_valid_q;
  assign is_circular_o     = circ_q;
  assign failed_rotation_o = fail_val_q;

endmodule

`default_nettype wire

/* rtl/core/cpt_ctrl.sv */
// Controller state machine sequencing digit count, rotations and trial division.
`default_nettype none

module cpt_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire cpt_pkg::cpt_sts_t  sts_i,
  output cpt_pkg::cpt_cmd_t       cmd_o
);
  import cpt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COUNT,
    ST_MOD_WAIT,
    ST_PRIME_INIT,
    ST_TRIAL_CHK,
    ST_TRIAL_WAIT,
    ST_ROT_HI,
    ST_ROT_UPD,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   fail_q, fail_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    fail_d  = fail_q;
    cmd_o   = '0;
    cmd_o.div_sel  = DIV_MODV;
    cmd_o.res_pass = !fail_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          fail_d        = 1'b0;
          state_d       = ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (sts_i.cnt_more) begin
          cmd_o.cnt_step = 1'b1;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_MODV;
          state_d         = ST_MOD_WAIT;
        end
      end
      ST_MOD_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.load_r_mod = 1'b1;
          state_d          = ST_PRIME_INIT;
        end
      end
      ST_PRIME_INIT: begin
        cmd_o.prime_init = 1'b1;
        state_d          = ST_TRIAL_CHK;
      end
      ST_TRIAL_CHK: begin
        priority if (sts_i.c_small) begin
          fail_d  = 1'b1;
          state_d = ST_FINISH;
        end else if (sts_i.sq_over) begin
          // This rotation is prime.
          if (sts_i.rot_last) begin
            state_d = ST_FINISH;
          end else begin
            cmd_o.rot_mul_lo = 1'b1;
            state_d          = ST_ROT_HI;
          end
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_TRIAL;
          state_d         = ST_TRIAL_WAIT;
        end
      end
      ST_TRIAL_WAIT: begin
        cmd_o.div_sel = DIV_TRIAL;
        if (sts_i.div_done) begin
          if (sts_i.rem_zero) begin
            fail_d  = 1'b1;
            state_d = ST_FINISH;
          end else begin
            cmd_o.trial_next = 1'b1;
            state_d          = ST_TRIAL_CHK;
          end
        end
      end
      ST_ROT_HI: begin
        cmd_o.rot_mul_hi = 1'b1;
        state_d          = ST_ROT_UPD;
      end
      ST_ROT_UPD: begin
        cmd_o.rot_update = 1'b1;
        state_d          = ST_PRIME_INIT;
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and the registered failure flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fail_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fail_q  <= fail_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

`default_nettype wire
